@@ src/x86_16_instruction_byte_decoder_assert.svh @@
// ---------------------------------------------------------------------------
// x86_16_instruction_byte_decoder_assert.svh
// Assertion macros shared by the decoder's checker.
// ---------------------------------------------------------------------------
`ifndef X86_16_INSTRUCTION_BYTE_DECODER_ASSERT_SVH
`define X86_16_INSTRUCTION_BYTE_DECODER_ASSERT_SVH

// Assertion that is switched off while reset is high.
`define XD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Assertion that also watches the reset cycles.
`define XD_ASSERT_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/x86dec_pkg.sv @@
// ---------------------------------------------------------------------------
// x86dec_pkg
// Types, opcode tables and decode helpers of the byte decoder.
// ---------------------------------------------------------------------------
package x86dec_pkg;

   typedef enum logic [3:0] {
      FORM_MOV_IMM_REG = 4'd0,
      FORM_MOV_IMM_MEM = 4'd1,
      FORM_MOV_RM      = 4'd2,
      FORM_MOV_MEM_ACC = 4'd3,
      FORM_MOV_ACC_MEM = 4'd4,
      FORM_PUSH_RM     = 4'd5,
      FORM_PUSH_REG    = 4'd6,
      FORM_POP_RM      = 4'd7,
      FORM_POP_REG     = 4'd8,
      FORM_XCHG_RM     = 4'd9,
      FORM_XCHG_ACC    = 4'd10,
      FORM_IN_FIX      = 4'd11,
      FORM_IN_VAR      = 4'd12,
      FORM_OUT_FIX     = 4'd13,
      FORM_OUT_VAR     = 4'd14,
      FORM_NONE        = 4'd15
   } form_type;

   localparam int NUM_FORMS = 15;
   localparam int NUM_MASKS = 5;

   // Form codes in form order; masks from longest to shortest.
   localparam logic [7:0] FORM_CODES [NUM_FORMS] = '{
      8'hb0, 8'hc6, 8'h88, 8'ha0, 8'ha2, 8'hff, 8'h50, 8'h8f,
      8'h58, 8'h86, 8'h90, 8'he4, 8'hec, 8'he6, 8'hee
   };
   localparam logic [7:0] TRY_MASKS [NUM_MASKS] = '{
      8'hff, 8'hfe, 8'hfc, 8'hf8, 8'hf0
   };

   localparam logic [1:0] MOD_REGISTER = 2'd3;
   localparam logic [1:0] MOD_MEM      = 2'd0;
   localparam logic [1:0] MOD_DISP8    = 2'd1;
   localparam logic [1:0] MOD_DISP16   = 2'd2;
   localparam logic [2:0] RM_DIRECT    = 3'd6;

   // Classified code byte as it travels from front to back.
   typedef struct packed {
      logic [7:0] code_byte;
      form_type   form;
   } q_entry_type;

   // Header length and counts of displacement and data bytes that follow.
   typedef struct packed {
      logic [1:0] hdr;
      logic [1:0] dcnt;
      logic [1:0] tcnt;
   } layout_type;

   typedef struct packed {
      logic [3:0]         form;
      logic [1:0]         mode;
      logic [2:0]         reg_field;
      logic [2:0]         rm_field;
      logic               wide;
      logic               direction;
      logic signed [15:0] displacement;
      logic [15:0]        immediate_or_address;
      logic [2:0]         length;
      logic               bad_opcode;
   } rec_type;

   function automatic form_type match_form(input logic [7:0] b);
      form_type   res;
      logic       found;
      logic [7:0] v;
      res   = FORM_NONE;
      found = 1'b0;
      for (int m = 0; m < NUM_MASKS; m++) begin
         v = b & TRY_MASKS[m];
         for (int f = 0; f < NUM_FORMS; f++) begin
            if (!found && FORM_CODES[f] == v) begin
               res   = form_type'(4'(f));
               found = 1'b1;
            end
         end
      end
      return res;
   endfunction

   function automatic logic has_modrm(input form_type f);
      return f == FORM_MOV_IMM_MEM || f == FORM_MOV_RM || f == FORM_PUSH_RM ||
             f == FORM_POP_RM || f == FORM_XCHG_RM;
   endfunction

   function automatic layout_type layout(input form_type f, input logic [7:0] first,
                                         input logic [7:0] modrm);
      layout_type l;
      logic       direct;
      logic [1:0] dsz;
      l.hdr  = 2'd1;
      l.dcnt = 2'd0;
      l.tcnt = 2'd0;
      direct = (modrm[7:6] == MOD_MEM) && (modrm[2:0] == RM_DIRECT);
      dsz    = (modrm[7:6] == MOD_DISP8)  ? 2'd1 :
               (modrm[7:6] == MOD_DISP16) ? 2'd2 : 2'd0;
      if (has_modrm(f)) begin
         l.hdr = 2'd2;
         if (f == FORM_MOV_IMM_MEM) begin
            l.dcnt = direct ? 2'd2 : dsz;
            l.tcnt = 2'd1 + {1'b0, first[0]};
         end else if (direct) begin
            l.tcnt = 2'd2;
         end else begin
            l.dcnt = dsz;
         end
      end else if (f == FORM_MOV_IMM_REG) begin
         l.tcnt = 2'd1 + {1'b0, first[3]};
      end else if (f == FORM_MOV_MEM_ACC || f == FORM_MOV_ACC_MEM) begin
         l.tcnt = 2'd2;
      end else if (f == FORM_IN_FIX || f == FORM_OUT_FIX) begin
         l.tcnt = 2'd1;
      end
      return l;
   endfunction

endpackage

@@ src/x86dec_front.sv @@
// ---------------------------------------------------------------------------
// x86dec_front
// Takes code words and tags each with the form it would open.
// ---------------------------------------------------------------------------
module x86dec_front (
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [7:0]               req_code_byte,
   input  logic                     q_full,
   output logic                     push,
   output x86dec_pkg::q_entry_type  push_entry
);

   assign req_ready            = !q_full;
   assign push                 = req_valid && req_ready;
   assign push_entry.code_byte = req_code_byte;
   assign push_entry.form      = x86dec_pkg::match_form(req_code_byte);

endmodule

@@ src/x86dec_queue.sv @@
// ---------------------------------------------------------------------------
// x86dec_queue
// Two-entry queue between classifier and assembler.
// ---------------------------------------------------------------------------
module x86dec_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  x86dec_pkg::q_entry_type  push_entry,
   output logic                     full,
   output logic                     q_valid,
   input  logic                     pop,
   output x86dec_pkg::q_entry_type  head
);

   x86dec_pkg::q_entry_type entry_ff [2];
   logic       wptr_ff, wptr_in;
   logic       rptr_ff, rptr_in;
   logic [1:0] count_ff, count_in;

   assign full    = (count_ff == 2'd2);
   assign q_valid = (count_ff != 2'd0);
   assign head    = entry_ff[rptr_ff];

   always_comb begin
      wptr_in  = push ? !wptr_ff : wptr_ff;
      rptr_in  = pop  ? !rptr_ff : rptr_ff;
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wptr_ff] <= push_entry;
      end
   end

endmodule

@@ src/x86dec_back.sv @@
// ---------------------------------------------------------------------------
// x86dec_back
// Assembles tagged words into instructions and registers each record.
// ---------------------------------------------------------------------------
module x86dec_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     q_valid,
   input  x86dec_pkg::q_entry_type  head,
   output logic                     pop,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output x86dec_pkg::rec_type      rsp_rec
);

   logic [2:0]           idx_ff, idx_in;
   logic [7:0]           first_ff, first_in;
   x86dec_pkg::form_type form_ff, form_in;
   logic [7:0]           modrm_ff, modrm_in;
   logic [2:0]           total_ff, total_in;
   logic [15:0]          disp_ff, disp_in;
   logic [15:0]          data_ff, data_in;

   logic                 valid_ff, valid_in;
   x86dec_pkg::rec_type  rec_ff, rec_in;

   x86dec_pkg::layout_type lay;
   x86dec_pkg::rec_type    rec;
   logic                   emit;
   logic [2:0]             off;
   logic [2:0]             doff;

   function automatic logic [2:0] total_of(input x86dec_pkg::layout_type l);
      return {1'b0, l.hdr} + {1'b0, l.dcnt} + {1'b0, l.tcnt};
   endfunction

   function automatic x86dec_pkg::rec_type build(input x86dec_pkg::form_type f,
                                                 input logic [7:0] b,
                                                 input logic [7:0] mr,
                                                 input logic [15:0] disp,
                                                 input logic [15:0] data,
                                                 input logic [2:0] len);
      x86dec_pkg::rec_type    r;
      x86dec_pkg::layout_type l;
      l = x86dec_pkg::layout(f, b, mr);
      r = '0;
      r.form = f;
      if (x86dec_pkg::has_modrm(f)) begin
         r.mode     = mr[7:6];
         r.rm_field = mr[2:0];
      end
      if (f == x86dec_pkg::FORM_MOV_RM || f == x86dec_pkg::FORM_XCHG_RM) begin
         r.reg_field = mr[5:3];
      end
      if (f == x86dec_pkg::FORM_MOV_IMM_REG || f == x86dec_pkg::FORM_PUSH_REG ||
          f == x86dec_pkg::FORM_POP_REG || f == x86dec_pkg::FORM_XCHG_ACC) begin
         r.reg_field = b[2:0];
      end
      if (f == x86dec_pkg::FORM_MOV_IMM_REG || f == x86dec_pkg::FORM_XCHG_ACC ||
          f == x86dec_pkg::FORM_IN_FIX || f == x86dec_pkg::FORM_IN_VAR ||
          f == x86dec_pkg::FORM_OUT_FIX || f == x86dec_pkg::FORM_OUT_VAR) begin
         r.mode = x86dec_pkg::MOD_REGISTER;
      end
      priority if (f == x86dec_pkg::FORM_MOV_IMM_REG) begin
         r.wide = b[3];
      end else if (f == x86dec_pkg::FORM_XCHG_ACC) begin
         r.wide = 1'b1;
      end else if (f == x86dec_pkg::FORM_PUSH_RM || f == x86dec_pkg::FORM_PUSH_REG ||
                   f == x86dec_pkg::FORM_POP_RM || f == x86dec_pkg::FORM_POP_REG) begin
         r.wide = 1'b0;
      end else begin
         r.wide = b[0];
      end
      priority if (f == x86dec_pkg::FORM_MOV_RM) begin
         r.direction = b[1];
      end else if (f == x86dec_pkg::FORM_MOV_IMM_REG || f == x86dec_pkg::FORM_MOV_MEM_ACC) begin
         r.direction = 1'b1;
      end else begin
         r.direction = 1'b0;
      end
      // Sign-extend a one-byte displacement.
      r.displacement = (l.dcnt == 2'd1) ? {{8{disp[7]}}, disp[7:0]} : disp;
      r.immediate_or_address = data;
      r.length               = len;
      return r;
   endfunction

   assign pop       = q_valid && (!valid_ff || rsp_ready);
   assign rsp_valid = valid_ff;
   assign rsp_rec   = rec_ff;

   always_comb begin
      idx_in   = idx_ff;
      first_in = first_ff;
      form_in  = form_ff;
      modrm_in = modrm_ff;
      total_in = total_ff;
      disp_in  = disp_ff;
      data_in  = data_ff;
      emit     = 1'b0;
      lay      = x86dec_pkg::layout(form_ff, first_ff, modrm_ff);
      off      = 3'd0;
      doff     = 3'd0;
      rec      = '0;
      if (pop) begin
         if (idx_ff == 3'd0) begin
            if (head.form == x86dec_pkg::FORM_NONE) begin
               // Unknown opcode: error record, stay at the first word.
               emit           = 1'b1;
               rec.length     = 3'd1;
               rec.bad_opcode = 1'b1;
            end else begin
               first_in = head.code_byte;
               form_in  = head.form;
               modrm_in = 8'h00;
               disp_in  = 16'h0000;
               data_in  = 16'h0000;
               idx_in   = 3'd1;
               if (x86dec_pkg::has_modrm(head.form)) begin
                  total_in = 3'd0;
               end else begin
                  lay      = x86dec_pkg::layout(head.form, head.code_byte, 8'h00);
                  total_in = total_of(lay);
                  emit     = (total_in <= 3'd1);
               end
            end
         end else if (idx_ff == 3'd1 && x86dec_pkg::has_modrm(form_ff)) begin
            modrm_in = head.code_byte;
            idx_in   = 3'd2;
            lay      = x86dec_pkg::layout(form_ff, first_ff, head.code_byte);
            total_in = total_of(lay);
            emit     = (total_in <= 3'd2);
         end else begin
            off  = idx_ff - {1'b0, lay.hdr};
            doff = off - {1'b0, lay.dcnt};
            if (off < {1'b0, lay.dcnt}) begin
               if (off[0]) begin
                  disp_in[15:8] = disp_ff[15:8] | head.code_byte;
               end else begin
                  disp_in[7:0] = disp_ff[7:0] | head.code_byte;
               end
            end else begin
               if (doff[0]) begin
                  data_in[15:8] = data_ff[15:8] | head.code_byte;
               end else begin
                  data_in[7:0] = data_ff[7:0] | head.code_byte;
               end
            end
            idx_in = idx_ff + 3'd1;
            emit   = (idx_in >= total_ff);
         end
         if (emit && !(idx_ff == 3'd0 && head.form == x86dec_pkg::FORM_NONE)) begin
            rec = build(form_in, first_in, modrm_in, disp_in, data_in, total_in);
         end
         if (emit) begin
            idx_in = 3'd0;
         end
      end
   end

   always_comb begin
      valid_in = valid_ff;
      rec_in   = rec_ff;
      if (pop && emit) begin
         valid_in = 1'b1;
         rec_in   = rec;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 3'd0;
         first_ff <= 8'h00;
         form_ff  <= x86dec_pkg::FORM_MOV_IMM_REG;
         modrm_ff <= 8'h00;
         total_ff <= 3'd0;
         disp_ff  <= 16'h0000;
         data_ff  <= 16'h0000;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         first_ff <= first_in;
         form_ff  <= form_in;
         modrm_ff <= modrm_in;
         total_ff <= total_in;
         disp_ff  <= disp_in;
         data_ff  <= data_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rec_ff <= rec_in;
   end

endmodule

@@ src/x86_16_instruction_byte_decoder.sv @@
// Path: each code word is registered in the queue; the finished record is registered at the output.
// Throughput: one code word per cycle while the output register is empty or being read.
// A stalled record holds in the output register; the queue takes words until both entries fill.
// Reset: synchronous, active high; clears queue, assembly state and rsp_valid.
// ---------------------------------------------------------------------------
// x86_16_instruction_byte_decoder
// Decodes a stream of 16-bit x86 code bytes into one record per instruction.
// ---------------------------------------------------------------------------
module x86_16_instruction_byte_decoder (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_code_byte,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [3:0]         rsp_form,
   output logic [1:0]         rsp_mode,
   output logic [2:0]         rsp_reg_field,
   output logic [2:0]         rsp_rm_field,
   output logic               rsp_wide,
   output logic               rsp_direction,
   output logic signed [15:0] rsp_displacement,
   output logic [15:0]        rsp_immediate_or_address,
   output logic [2:0]         rsp_length,
   output logic               rsp_bad_opcode
);

   // Front to queue: classified word.
   logic                    push;
   x86dec_pkg::q_entry_type push_entry;
   logic                    q_full;

   // Queue to back.
   logic                    q_valid;
   logic                    pop;
   x86dec_pkg::q_entry_type head;

   x86dec_pkg::rec_type     rec;

   // Classify every word: the back only uses the tag on a first word.
   x86dec_front u_front (
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_code_byte (req_code_byte),
      .q_full        (q_full),
      .push          (push),
      .push_entry    (push_entry)
   );

   // Hold up to two tagged words so a stalled output does not stall fetch at once.
   x86dec_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (q_full),
      .q_valid    (q_valid),
      .pop        (pop),
      .head       (head)
   );

   // Advance the instruction assembly; register each finished record.
   x86dec_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_rec   (rec)
   );

   assign rsp_form                 = rec.form;
   assign rsp_mode                 = rec.mode;
   assign rsp_reg_field            = rec.reg_field;
   assign rsp_rm_field             = rec.rm_field;
   assign rsp_wide                 = rec.wide;
   assign rsp_direction            = rec.direction;
   assign rsp_displacement         = rec.displacement;
   assign rsp_immediate_or_address = rec.immediate_or_address;
   assign rsp_length               = rec.length;
   assign rsp_bad_opcode           = rec.bad_opcode;

endmodule

@@ src/x86dec_checker.sv @@
// ---------------------------------------------------------------------------
// x86dec_checker
// Port-level checks of the decoder, bound to the top level.
// ---------------------------------------------------------------------------
`include "x86_16_instruction_byte_decoder_assert.svh"

module x86dec_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic [7:0]         req_code_byte,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [3:0]         rsp_form,
   input logic [1:0]         rsp_mode,
   input logic [2:0]         rsp_reg_field,
   input logic [2:0]         rsp_rm_field,
   input logic               rsp_wide,
   input logic               rsp_direction,
   input logic signed [15:0] rsp_displacement,
   input logic [15:0]        rsp_immediate_or_address,
   input logic [2:0]         rsp_length,
   input logic               rsp_bad_opcode
);

   // A stalled record holds.
   `XD_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_length) && $stable(rsp_form) && $stable(rsp_displacement) && $stable(rsp_immediate_or_address), "stalled record changed")

   // An error record is one word long and carries nothing else.
   `XD_ASSERT(a_bad_record, clock, reset, rsp_valid && rsp_bad_opcode |-> rsp_length == 3'd1 && rsp_form == 4'd0 && rsp_mode == 2'd0 && rsp_displacement == 16'sd0 && rsp_immediate_or_address == 16'd0, "malformed error record")

   // Every record names a real form and a length of one to six words.
   `XD_ASSERT(a_len_form, clock, reset, rsp_valid |-> rsp_form != 4'd15 && rsp_length != 3'd0 && rsp_length != 3'd7, "record form or length out of range")

   // Nothing is offered straight after reset.
   `XD_ASSERT_NR(a_reset_quiet, clock, $past(reset) && !reset |-> !rsp_valid, "record offered after reset")

endmodule

bind x86_16_instruction_byte_decoder x86dec_checker u_x86dec_checker (.*);

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Feeds the byte decoder with code words: one of each instruction form, the
// awkward encodings (direct address, sign-extended byte displacement, loose
// opcode matches, register mode, unknown opcodes), then a long stream of
// mostly well-formed instructions with random content and a noise burst.
// A local decoder model predicts every record, and each record that leaves
// the block is compared field by field with the oldest prediction.
// ---------------------------------------------------------------------------
module testbench;

   localparam int QUIET_LIMIT  = 2000;   // cycles with no word moving on either side
   localparam int DRAIN_CYCLES = 8;      // settle time once every record is home
   localparam int STREAM_BYTES = 1600;   // code words sent in all, at least, by the end of the random stream
   localparam int NOISE_BYTES  = 200;

   // -----------------------------------------------------------------------
   // Clock, reset and DUT ports. Every input is known from time zero.
   // -----------------------------------------------------------------------
   logic               clock         = 1'b0;
   logic               reset         = 1'b1;
   logic               req_valid     = 1'b0;
   logic               req_ready;
   logic [7:0]         req_code_byte = 8'h00;
   logic               rsp_valid;
   logic               rsp_ready     = 1'b0;
   logic [3:0]         rsp_form;
   logic [1:0]         rsp_mode;
   logic [2:0]         rsp_reg_field;
   logic [2:0]         rsp_rm_field;
   logic               rsp_wide;
   logic               rsp_direction;
   logic signed [15:0] rsp_displacement;
   logic [15:0]        rsp_immediate_or_address;
   logic [2:0]         rsp_length;
   logic               rsp_bad_opcode;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   x86_16_instruction_byte_decoder u_dut (.*);

   // -----------------------------------------------------------------------
   // Shared state of the run
   // -----------------------------------------------------------------------
   x86dec_pkg::rec_type decoded_records [$];   // records the model has produced, oldest first
   x86dec_pkg::rec_type want;
   int      mismatch_count = 0;
   int      bytes_sent     = 0;
   int      quiet_cycles   = 0;
   int      ready_hold     = 0;
   logic    gaps_on        = 1'b1; // sender draws random gaps when set
   logic    stalls_on      = 1'b1; // receiver draws random stalls when set

   // Decoder model state: where we are in the current instruction and what
   // has been gathered so far.
   int                   bytes_taken = 0;
   logic [7:0]           opcode      = 8'h00;
   x86dec_pkg::form_type cur_form    = x86dec_pkg::FORM_MOV_IMM_REG;
   logic [7:0]           modrm       = 8'h00;
   int                   instr_len   = 0;
   logic [15:0]          disp_word   = 16'h0000;
   logic [15:0]          data_word   = 16'h0000;

   // -----------------------------------------------------------------------
   // Decoder model
   // -----------------------------------------------------------------------

   // Try the masks from longest to shortest; first hit on a form code wins.
   function automatic x86dec_pkg::form_type classify(input logic [7:0] b);
      logic [7:0] masked;
      for (int k = 0; k < x86dec_pkg::NUM_MASKS; k++) begin
         masked = b & (8'hff << k);
         for (int f = 0; f < x86dec_pkg::NUM_FORMS; f++)
            if (x86dec_pkg::FORM_CODES[f] == masked)
               return x86dec_pkg::form_type'(4'(f));
      end
      return x86dec_pkg::FORM_NONE;
   endfunction

   function automatic logic takes_modrm(input x86dec_pkg::form_type f);
      case (f)
         x86dec_pkg::FORM_MOV_IMM_MEM, x86dec_pkg::FORM_MOV_RM, x86dec_pkg::FORM_PUSH_RM,
         x86dec_pkg::FORM_POP_RM, x86dec_pkg::FORM_XCHG_RM:
            return 1'b1;
         default:
            return 1'b0;
      endcase
   endfunction

   // Header bytes, then how many displacement and data bytes follow them.
   function automatic void frame_layout(input x86dec_pkg::form_type f,
                                        input logic [7:0] first,
                                        input logic [7:0] mrm,
                                        output int hdr, output int dcnt, output int tcnt);
      logic direct;
      int   dsz;
      direct = (mrm[7:6] == x86dec_pkg::MOD_MEM) && (mrm[2:0] == x86dec_pkg::RM_DIRECT);
      dsz    = (mrm[7:6] == x86dec_pkg::MOD_DISP8)  ? 1 :
               (mrm[7:6] == x86dec_pkg::MOD_DISP16) ? 2 : 0;
      hdr    = 1;
      dcnt   = 0;
      tcnt   = 0;
      if (takes_modrm(f)) begin
         hdr = 2;
         // A direct address is always two bytes, whatever the w bit says.
         if (f == x86dec_pkg::FORM_MOV_IMM_MEM) begin
            dcnt = direct ? 2 : dsz;
            tcnt = 1 + first[0];
         end else if (direct) begin
            tcnt = 2;
         end else begin
            dcnt = dsz;
         end
      end else begin
         case (f)
            x86dec_pkg::FORM_MOV_IMM_REG:
               tcnt = 1 + first[3];
            x86dec_pkg::FORM_MOV_MEM_ACC, x86dec_pkg::FORM_MOV_ACC_MEM:
               tcnt = 2;
            x86dec_pkg::FORM_IN_FIX, x86dec_pkg::FORM_OUT_FIX:
               tcnt = 1;
            default:
               tcnt = 0;
         endcase
      end
   endfunction

   // Advance the model by one accepted code word; queue a record when an
   // instruction completes or the opcode is unknown.
   function automatic void decode_byte(input logic [7:0] b);
      x86dec_pkg::rec_type  r;
      x86dec_pkg::form_type f;
      int                   hdr, dcnt, tcnt, off;
      r = '0;
      if (bytes_taken == 0) begin
         f = classify(b);
         if (f == x86dec_pkg::FORM_NONE) begin
            // Unknown opcode: error record at once, state untouched.
            r.length     = 3'd1;
            r.bad_opcode = 1'b1;
            decoded_records.push_back(r);
            return;
         end
         opcode      = b;
         cur_form    = f;
         modrm       = 8'h00;
         disp_word   = 16'h0000;
         data_word   = 16'h0000;
         bytes_taken = 1;
         if (takes_modrm(f)) begin
            instr_len = 0;
            return;
         end
         frame_layout(f, b, 8'h00, hdr, dcnt, tcnt);
         instr_len = hdr + dcnt + tcnt;
      end else if (bytes_taken == 1 && takes_modrm(cur_form)) begin
         modrm       = b;
         bytes_taken = 2;
         frame_layout(cur_form, opcode, b, hdr, dcnt, tcnt);
         instr_len = hdr + dcnt + tcnt;
      end else begin
         frame_layout(cur_form, opcode, modrm, hdr, dcnt, tcnt);
         off = bytes_taken - hdr;
         if (off < dcnt)
            disp_word |= {8'h00, b} << (8 * (off & 1));
         else
            data_word |= {8'h00, b} << (8 * ((off - dcnt) & 1));
         bytes_taken++;
      end

      if (bytes_taken < instr_len) return;

      // Instruction complete: assemble the record.
      frame_layout(cur_form, opcode, modrm, hdr, dcnt, tcnt);
      r.form = cur_form;
      if (takes_modrm(cur_form)) begin
         r.mode     = modrm[7:6];
         r.rm_field = modrm[2:0];
      end
      case (cur_form)
         x86dec_pkg::FORM_MOV_RM, x86dec_pkg::FORM_XCHG_RM:
            r.reg_field = modrm[5:3];
         x86dec_pkg::FORM_MOV_IMM_REG, x86dec_pkg::FORM_PUSH_REG,
         x86dec_pkg::FORM_POP_REG, x86dec_pkg::FORM_XCHG_ACC:
            r.reg_field = opcode[2:0];
         default: ;
      endcase
      case (cur_form)
         x86dec_pkg::FORM_MOV_IMM_REG, x86dec_pkg::FORM_XCHG_ACC, x86dec_pkg::FORM_IN_FIX,
         x86dec_pkg::FORM_IN_VAR, x86dec_pkg::FORM_OUT_FIX, x86dec_pkg::FORM_OUT_VAR:
            r.mode = x86dec_pkg::MOD_REGISTER;
         default: ;
      endcase
      case (cur_form)
         x86dec_pkg::FORM_MOV_IMM_REG:
            r.wide = opcode[3];
         x86dec_pkg::FORM_XCHG_ACC:
            r.wide = 1'b1;
         x86dec_pkg::FORM_PUSH_RM, x86dec_pkg::FORM_PUSH_REG,
         x86dec_pkg::FORM_POP_RM, x86dec_pkg::FORM_POP_REG:
            r.wide = 1'b0;
         default:
            r.wide = opcode[0];
      endcase
      case (cur_form)
         x86dec_pkg::FORM_MOV_RM:
            r.direction = opcode[1];
         x86dec_pkg::FORM_MOV_IMM_REG, x86dec_pkg::FORM_MOV_MEM_ACC:
            r.direction = 1'b1;
         default:
            r.direction = 1'b0;
      endcase
      // A byte displacement is sign-extended to the full word.
      r.displacement = (dcnt == 1) ? {{8{disp_word[7]}}, disp_word[7:0]} : disp_word;
      r.immediate_or_address = data_word;
      r.length               = 3'(instr_len);
      decoded_records.push_back(r);
      bytes_taken = 0;
   endfunction

   // -----------------------------------------------------------------------
   // Sender: hold the word until taken, then run it through the model
   // -----------------------------------------------------------------------
   task automatic send_code(input logic [7:0] b);
      int gap;
      gap = gaps_on ? $urandom_range(0, 10) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_code_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      decode_byte(b);
      bytes_sent++;
   endtask

   task automatic send_codes(input logic [7:0] codes [$]);
      foreach (codes[i]) send_code(codes[i]);
   endtask

   // One instruction of the given form: random opcode bits, random r/m byte
   // (often forced to a direct address), random trailing bytes.
   task automatic send_instruction(input x86dec_pkg::form_type f);
      logic [7:0] first, mrm;
      int         hdr, dcnt, tcnt;
      do first = 8'($urandom); while (classify(first) != f);
      send_code(first);
      mrm = 8'h00;
      if (takes_modrm(f)) begin
         mrm = 8'($urandom);
         if ($urandom_range(0, 4) == 0)
            mrm = {x86dec_pkg::MOD_MEM, mrm[5:3], x86dec_pkg::RM_DIRECT};
         send_code(mrm);
      end
      frame_layout(f, first, mrm, hdr, dcnt, tcnt);
      repeat (dcnt + tcnt) send_code(8'($urandom));
   endtask

   // Draw a new idling mix; each side runs flat out in about one stretch in four.
   task automatic shuffle_idling();
      gaps_on   = ($urandom_range(0, 3) != 0);
      stalls_on = ($urandom_range(0, 3) != 0);
   endtask

   // -----------------------------------------------------------------------
   // Receiver: after each record, stall a random number of cycles
   // -----------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         ready_hold = 0;
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready)
            ready_hold = stalls_on ? $urandom_range(0, 10) : 0;
         else if (ready_hold > 0)
            ready_hold--;
         rsp_ready <= (ready_hold == 0);
      end
   end

   // -----------------------------------------------------------------------
   // Record checker
   // -----------------------------------------------------------------------
   function automatic void check_field(input string name, input logic [15:0] exp_val,
                                       input logic [15:0] act_val);
      if (exp_val !== act_val) begin
         $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_val, act_val);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (decoded_records.size() == 0) begin
            $display("%0t: record with nothing pending, form %0d length %0d bad %0b",
                     $time, rsp_form, rsp_length, rsp_bad_opcode);
            mismatch_count++;
         end else begin
            want = decoded_records.pop_front();
            check_field("form",         16'(want.form),        16'(rsp_form));
            check_field("mode",         16'(want.mode),        16'(rsp_mode));
            check_field("reg_field",    16'(want.reg_field),   16'(rsp_reg_field));
            check_field("rm_field",     16'(want.rm_field),    16'(rsp_rm_field));
            check_field("wide",         16'(want.wide),        16'(rsp_wide));
            check_field("direction",    16'(want.direction),   16'(rsp_direction));
            check_field("displacement", want.displacement,     rsp_displacement);
            check_field("immediate_or_address", want.immediate_or_address,
                        rsp_immediate_or_address);
            check_field("length",       16'(want.length),      16'(rsp_length));
            check_field("bad_opcode",   16'(want.bad_opcode),  16'(rsp_bad_opcode));
         end
      end
   end

   // -----------------------------------------------------------------------
   // Watchdog: drop the run if no word moves on either side for too long
   // -----------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("x86_16_instruction_byte_decoder verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // -----------------------------------------------------------------------
   // Tests
   // -----------------------------------------------------------------------

   // One plain instance of every form but mov mem-to-acc and push r/m, register mode where an r/m byte exists.
   task automatic test_each_form();
      send_codes('{
         x86dec_pkg::FORM_CODES[x86dec_pkg::FORM_MOV_IMM_REG], 8'hff,    // mov al, ff
         x86dec_pkg::FORM_CODES[x86dec_pkg::FORM_MOV_IMM_MEM],
         {x86dec_pkg::MOD_REGISTER, 3'd0, 3'd3}, 8'h5a,
         x86dec_pkg::FORM_CODES[x86dec_pkg::FORM_MOV_RM] | 8'h03,        // d and w set
         {x86dec_pkg::MOD_REGISTER, 3'd7, 3'd0},
         x86dec_pkg::FORM_CODES[x86dec_pkg::FORM_MOV_ACC_MEM] | 8'h01, 8'hff, 8'hff,
         x86dec_pkg::FORM_CODES[x86dec_pkg::FORM_PUSH_REG] | 8'h07,
         x86dec_pkg::FORM_CODES[x86dec_pkg::FORM_POP_RM],
         {x86dec_pkg::MOD_REGISTER, 3'd0, 3'd1},
         x86dec_pkg::FORM_CODES[x86dec_pkg::FORM_POP_REG],
         x86dec_pkg::FORM_CODES[x86dec_pkg::FORM_XCHG_RM] | 8'h01,
         {x86dec_pkg::MOD_REGISTER, 3'd5, 3'd2},
         x86dec_pkg::FORM_CODES[x86dec_pkg::FORM_XCHG_ACC] | 8'h03,
         x86dec_pkg::FORM_CODES[x86dec_pkg::FORM_IN_FIX] | 8'h01, 8'h7f,
         x86dec_pkg::FORM_CODES[x86dec_pkg::FORM_IN_VAR],
         x86dec_pkg::FORM_CODES[x86dec_pkg::FORM_OUT_FIX], 8'hff,
         x86dec_pkg::FORM_CODES[x86dec_pkg::FORM_OUT_VAR] | 8'h01
      });
   endtask

   task automatic test_special_cases();
      send_codes('{
         // longest instruction: direct address plus word immediate
         x86dec_pkg::FORM_CODES[x86dec_pkg::FORM_MOV_IMM_MEM] | 8'h01,
         {x86dec_pkg::MOD_MEM, 3'd0, x86dec_pkg::RM_DIRECT},
         8'h34, 8'h12, 8'hff, 8'hff,
         // direct address in mov r/m is two bytes even with w clear
         x86dec_pkg::FORM_CODES[x86dec_pkg::FORM_MOV_RM],
         {x86dec_pkg::MOD_MEM, 3'd6, x86dec_pkg::RM_DIRECT}, 8'hcd, 8'hab,
         // negative byte displacement, sign-extended
         x86dec_pkg::FORM_CODES[x86dec_pkg::FORM_PUSH_RM],
         {x86dec_pkg::MOD_DISP8, 3'd6, 3'd7}, 8'h80,
         // word displacement at the extreme
         x86dec_pkg::FORM_CODES[x86dec_pkg::FORM_POP_RM],
         {x86dec_pkg::MOD_DISP16, 3'd0, 3'd7}, 8'hff, 8'h7f,
         // loose mask matches: mov r/m, mov mem-to-acc, xchg with accumulator
         x86dec_pkg::FORM_CODES[x86dec_pkg::FORM_MOV_RM] | 8'h06,
         {x86dec_pkg::MOD_REGISTER, 3'd3, 3'd0},
         x86dec_pkg::FORM_CODES[x86dec_pkg::FORM_MOV_MEM_ACC] | 8'h05, 8'h01, 8'h02,
         x86dec_pkg::FORM_CODES[x86dec_pkg::FORM_XCHG_ACC] | 8'h0f,
         // no form matches these two opcodes
         8'h00, 8'h0f
      });
   endtask

   // Mostly well-formed instructions, evenly over the forms, with a few
   // unknown opcodes mixed in.
   task automatic test_random_instructions();
      logic [7:0] junk;
      int         count;
      count = 0;
      while (bytes_sent < STREAM_BYTES) begin
         if (count % 50 == 0) shuffle_idling();
         count++;
         if ($urandom_range(0, 19) == 0) begin
            do junk = 8'($urandom); while (classify(junk) != x86dec_pkg::FORM_NONE);
            send_code(junk);
         end else begin
            send_instruction(x86dec_pkg::form_type'(
               4'($urandom_range(0, x86dec_pkg::NUM_FORMS - 1))));
         end
      end
   endtask

   // Raw bytes: broken sequences, unknown opcodes, anything at all.
   task automatic test_random_noise();
      for (int i = 0; i < NOISE_BYTES; i++) begin
         if (i % 40 == 0) shuffle_idling();
         send_code(8'($urandom));
      end
   endtask

   // -----------------------------------------------------------------------
   // Sequence of the run
   // -----------------------------------------------------------------------
   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_each_form();
      test_special_cases();
      test_random_instructions();
      test_random_noise();

      // Stop sending, let every record come home, then allow for stragglers.
      req_valid <= 1'b0;
      while (decoded_records.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0)
         $display("x86_16_instruction_byte_decoder verification clean");
      else
         $display("x86_16_instruction_byte_decoder verification failed");
      $finish;
   end

endmodule
